/* sv/assert_macros.svh */
// Assertion macros for the literal pool find-or-insert RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/lpfi_pkg.sv */
// Package: widths and defaults for the literal pool find-or-insert block
package lpfi_pkg;

  localparam int POOL_DEPTH_DEF = 64;
  localparam int VALUE_W        = 32;
  localparam int INDEX_W        = 6;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 8;

endpackage

/* sv/literal_pool_find_or_insert.sv */
// Sequence: accept the request, scan up to entry_count entries, then post the result.
// The scan reads one entry per cycle through the single read port; an empty pool skips it.
// A new request is accepted only in idle, after the previous one has posted its result.
// Requests are taken while an earlier result waits; a second result stalls until it drains.
// Reset (rst_n, synchronous, active low) clears the entry count and control state;
// pool memory contents are not cleared, only entries below the count are compared.
module literal_pool_find_or_insert #(
  parameter int POOL_DEPTH = lpfi_pkg::POOL_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lpfi_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] lookup_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lpfi_pkg::OUT_TDATA_W-1:0]  out_tdata   // [5:0] entry_index, [6] is_new,
                                                        // [7] table_full
);

  import lpfi_pkg::*;
`include "assert_macros.svh"

  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [VALUE_W-1:0] pool_mem [POOL_DEPTH];

  logic [1:0]         state_r,    state_nxt;
  logic [CNT_W-1:0]   count_r,    count_nxt;
  logic [CNT_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic               cmp_vld_r,  cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r,  cmp_idx_nxt;
  logic [VALUE_W-1:0] value_r,    value_nxt;
  logic [VALUE_W-1:0] rd_data_r;
  logic [IDX_W-1:0]   res_idx_r,  res_idx_nxt;
  logic               res_new_r,  res_new_nxt;
  logic               res_full_r, res_full_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [IDX_W-1:0]   out_idx_r,  out_idx_nxt;
  logic               out_new_r,  out_new_nxt;
  logic               out_full_r, out_full_nxt;

  logic               match;
  logic               pool_full;
  logic               out_free;
  logic               mem_we;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W+INDEX_W-1:0] idx_ext;

  assign match     = cmp_vld_r && (rd_data_r == value_r);
  assign pool_full = (count_r == CNT_FULL);
  assign out_free  = !out_tvalid_r || out_tready;
  assign rd_addr   = scan_cnt_r[IDX_W-1:0];
  assign wr_addr   = count_r[IDX_W-1:0];
  assign mem_we    = (state_r == ST_DONE) && out_free && res_new_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign idx_ext    = {{INDEX_W{1'b0}}, out_idx_r};
  assign out_tdata  = {out_full_r, out_new_r, idx_ext[INDEX_W-1:0]};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_cnt_nxt   = scan_cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    value_nxt      = value_r;
    res_idx_nxt    = res_idx_r;
    res_new_nxt    = res_new_r;
    res_full_nxt   = res_full_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_idx_nxt    = out_idx_r;
    out_new_nxt    = out_new_r;
    out_full_nxt   = out_full_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          value_nxt    = in_tdata[VALUE_W-1:0];
          scan_cnt_nxt = '0;
          if (count_r == '0) begin
            res_idx_nxt  = '0;
            res_new_nxt  = 1'b1;
            res_full_nxt = 1'b0;
            state_nxt    = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          res_idx_nxt  = cmp_idx_r;
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          state_nxt    = ST_DONE;
        end else if (scan_cnt_r == count_r) begin
          res_idx_nxt  = pool_full ? '0 : wr_addr;
          res_new_nxt  = !pool_full;
          res_full_nxt = pool_full;
          state_nxt    = ST_DONE;
        end else begin
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = rd_addr;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_idx_nxt    = res_idx_r;
          out_new_nxt    = res_new_r;
          out_full_nxt   = res_full_r;
          if (res_new_r) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      cmp_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt_r <= scan_cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    value_r    <= value_nxt;
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    out_idx_r  <= out_idx_nxt;
    out_new_r  <= out_new_nxt;
    out_full_r <= out_full_nxt;
  end

  // pool memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pool_mem[wr_addr] <= value_r;
    end
    rd_data_r <= pool_mem[rd_addr];
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_FULL)
  `ASSERT_IMPL(a_cmp_in_scan, clk, rst_n, cmp_vld_r, state_r == ST_SCAN)
  `ASSERT_IMPL(a_flags_excl, clk, rst_n, out_tvalid_r, !(out_new_r && out_full_r))
  `ASSERT_NEXT(a_append_count, clk, rst_n, mem_we, count_r == $past(count_r) + 1'b1)

endmodule
